// ----- rtl/decimal_comma_formatter_top_defines.svh -----
// Assertion macros shared by the formatter RTL.
// Each use sits on a line of its own inside a module that has clk and rst_n.
`ifndef DECIMAL_COMMA_FORMATTER_TOP_DEFINES_SVH
`define DECIMAL_COMMA_FORMATTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define DCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define DCF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DCF_ASSERT(lbl, prop, msg)
`define DCF_NEVER(lbl, cond, msg)

`endif

`endif

// ----- rtl/dcf_pkg.sv -----
package dcf_pkg;

  // Decimal digits of a 32-bit unsigned value
  localparam int NumDigits = 10;
  localparam int DigitW    = 4;
  localparam int ValueW    = 32;
  localparam int StepW     = $clog2(ValueW);
  localparam int LenW      = 4;
  localparam int CharW     = 8;
  localparam int BufW      = 8;

  // Reset value of the buffer size register
  localparam logic [BufW-1:0] BufSizeReset = 8'd14;

  // ASCII codes
  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiComma = 8'h2C;

  // Queue between converter and emitter (depth a power of two)
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef logic [NumDigits-1:0][DigitW-1:0] dcf_bcd_t;

  // One converted value waiting to be emitted
  typedef struct packed {
    dcf_bcd_t        digits;  // BCD, digit 0 least significant
    logic [LenW-1:0] ndig;    // significant digits, 1..10
    logic [LenW-1:0] len;     // text length including commas
    logic            ok;      // text fits the buffer
  } dcf_entry_t;

  // Text length for a digit count: digits plus one comma per full group of three digits below the most significant one
  function automatic logic [LenW-1:0] dcf_text_len(input logic [LenW-1:0] ndig);
    logic [LenW-1:0] len;
    case (ndig)
      4'd1:    len = 4'd1;
      4'd2:    len = 4'd2;
      4'd3:    len = 4'd3;
      4'd4:    len = 4'd5;
      4'd5:    len = 4'd6;
      4'd6:    len = 4'd7;
      4'd7:    len = 4'd9;
      4'd8:    len = 4'd10;
      4'd9:    len = 4'd11;
      4'd10:   len = 4'd13;
      default: len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/dcf_front.sv -----
`include "decimal_comma_formatter_top_defines.svh"

module dcf_front import dcf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ValueW-1:0] in_value,
  input  logic [BufW-1:0]  buf_size,
  output logic             q_push,
  output dcf_entry_t       q_wdata,
  input  logic             q_full
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_PUSH} state_t;

  state_t            state_r;
  logic [ValueW-1:0] bin_r;
  dcf_bcd_t          bcd_r;
  dcf_bcd_t          bcd_adj;
  dcf_bcd_t          bcd_nxt;
  logic [NumDigits*DigitW-1:0] bcd_flat;
  logic [StepW-1:0]  cnt_r;
  logic [LenW-1:0]   ndig;
  logic [LenW-1:0]   len;
  logic              in_accept;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Double-dabble step: add 3 to digits of 5 or more, then shift in next bit
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_flat = bcd_adj;
    bcd_nxt  = {bcd_flat[NumDigits*DigitW-2:0], bin_r[ValueW-1]};
  end

  // Digit count from the highest nonzero digit; zero still has one digit
  always_comb begin
    ndig = 4'd1;
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd_r[i] != '0) ndig = LenW'(i + 1);
    end
  end

  assign len = dcf_text_len(ndig);

  // Text plus terminator must fit: len <= buf_size - 1, len is at least 1
  assign q_wdata.digits = bcd_r;
  assign q_wdata.ndig   = ndig;
  assign q_wdata.len    = len;
  assign q_wdata.ok     = ({{(BufW-LenW){1'b0}}, len} < buf_size);
  assign q_push         = (state_r == S_PUSH) && !q_full;

  // Sequencer: load, 32 shift-add steps, hand over to the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            bin_r   <= in_value;
            bcd_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          bcd_r <= bcd_nxt;
          bin_r <= bin_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == StepW'(ValueW - 1)) state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DCF_ASSERT(a_accept_starts_conv, in_accept |=> (state_r == S_CONV) && (cnt_r == '0), "front: accepted transaction did not start conversion")
  `DCF_ASSERT(a_conv_length, (state_r == S_PUSH) && $past(state_r == S_CONV) |-> $past(cnt_r) == StepW'(ValueW - 1), "front: conversion ended early")

endmodule

// ----- rtl/dcf_queue.sv -----
`include "decimal_comma_formatter_top_defines.svh"

module dcf_queue import dcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_push,
  input  dcf_entry_t q_wdata,
  output logic       q_full,
  input  logic       q_pop,
  output dcf_entry_t q_rdata,
  output logic       q_valid
);

  dcf_entry_t       mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] cnt_r;

  assign q_full  = (cnt_r == QCntW'(QDepth));
  assign q_valid = (cnt_r != '0);
  assign q_rdata = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (q_push) mem_r[wr_ptr_r] <= q_wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({q_push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `DCF_NEVER(a_no_overflow, q_push && q_full, "queue: push while full")
  `DCF_NEVER(a_no_underflow, q_pop && !q_valid, "queue: pop while empty")

endmodule

// ----- rtl/dcf_back.sv -----
`include "decimal_comma_formatter_top_defines.svh"

module dcf_back import dcf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dcf_entry_t       q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] out_char,
  output logic             out_char_valid,
  output logic             out_last,
  output logic [LenW-1:0]  out_total_length
);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t           state_r;
  dcf_entry_t       ent_r;
  logic [LenW-1:0]  di_r;      // index of next digit to emit
  logic             comma_r;   // comma due before that digit
  logic             out_valid_r;
  logic [CharW-1:0] out_char_r;
  logic             out_char_valid_r;
  logic             out_last_r;
  logic [LenW-1:0]  out_total_length_r;

  logic [CharW-1:0] cur_char;
  logic             cur_cv;
  logic             cur_last;
  logic [LenW-1:0]  cur_len;
  logic             advance;

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign advance = !out_valid_r || !out_stall;

  // Next character of the current transaction
  always_comb begin
    if (!ent_r.ok) begin
      cur_char = '0;
      cur_cv   = 1'b0;
      cur_last = 1'b1;
      cur_len  = '0;
    end else if (comma_r) begin
      cur_char = AsciiComma;
      cur_cv   = 1'b1;
      cur_last = 1'b0;
      cur_len  = ent_r.len;
    end else begin
      cur_char = AsciiZero | {{(CharW-DigitW){1'b0}}, ent_r.digits[di_r]};
      cur_cv   = 1'b1;
      cur_last = (di_r == '0);
      cur_len  = ent_r.len;
    end
  end

  // Emitter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      comma_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          // last character of the previous transaction leaves when taken
          if (!out_stall) out_valid_r <= 1'b0;
          if (q_valid) begin
            ent_r   <= q_rdata;
            di_r    <= q_rdata.ndig - 1'b1;
            comma_r <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (advance) begin
            out_valid_r        <= 1'b1;
            out_char_r         <= cur_char;
            out_char_valid_r   <= cur_cv;
            out_last_r         <= cur_last;
            out_total_length_r <= cur_len;
            if (cur_last) begin
              state_r <= S_IDLE;
            end else if (comma_r) begin
              comma_r <= 1'b0;
            end else begin
              di_r    <= di_r - 1'b1;
              comma_r <= (di_r == 4'd3) || (di_r == 4'd6) || (di_r == 4'd9);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_char_valid   = out_char_valid_r;
  assign out_last         = out_last_r;
  assign out_total_length = out_total_length_r;

  `DCF_ASSERT(a_fail_is_single, out_valid_r && !out_char_valid_r |-> out_last_r && (out_total_length_r == '0), "back: failed transaction result malformed")
  `DCF_NEVER(a_comma_not_at_end, (state_r == S_EMIT) && comma_r && (di_r == '0), "back: comma pending after last digit")

endmodule

// ----- rtl/decimal_comma_formatter_top.sv -----
// Decimal comma formatter: each accepted 32-bit value comes out as its
// decimal ASCII text, most significant character first, one character per
// output transaction, with a comma between groups of three digits (zero gives
// "0"). Every character carries the total text length, and the final one is
// marked last. If buffer_size is below 2, or the text does not fit in
// buffer_size - 1 bytes, a single transaction with char_valid low, last high,
// char 0 and length 0 is sent instead. A converter takes one value at a time
// (one load, 32 shift-add steps, one hand-off) and, unless the output stalls,
// is the limit on sustained input rate; a two-entry queue lets it work on the
// next value while the emitter sends up to 13 characters at one per cycle
// while out_stall is low. buffer_size resets to 14 and should be written only
// while the block is idle; cfg_ready is always high.
module decimal_comma_formatter_top import dcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BufW-1:0]   cfg_buffer_size,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ValueW-1:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CharW-1:0]  out_char,
  output logic              out_char_valid,
  output logic              out_last,
  output logic [LenW-1:0]   out_total_length
);

  logic [BufW-1:0] buf_size_r;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  dcf_entry_t      q_wdata;
  dcf_entry_t      q_rdata;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BufSizeReset;
    end else if (cfg_valid && cfg_ready) begin
      buf_size_r <= cfg_buffer_size;
    end
  end

  dcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .buf_size (buf_size_r),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  dcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_valid (q_valid)
  );

  dcf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_last         (out_last),
    .out_total_length (out_total_length)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dcf_pkg::*;

  // One emitted character as seen on the result channel
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             valid;
    logic             last;
    logic [LenW-1:0]  total;
  } text_char_t;

  // Directed row: buffer size to load first (-1 keeps it), value, and the
  // typed text where it is known by eye ("" with typed set means no fit)
  typedef struct {
    int              buf_sel;
    logic [ValueW-1:0] value;
    bit              typed;
    string           text;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BufW-1:0]   cfg_buffer_size = BufSizeReset;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ValueW-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CharW-1:0]  out_char;
  logic              out_char_valid;
  logic              out_last;
  logic [LenW-1:0]   out_total_length;

  text_char_t  pending_chars[$];
  int unsigned buf_size = BufSizeReset;
  int          errors = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;

  decimal_comma_formatter_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_buffer_size  (cfg_buffer_size),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_last         (out_last),
    .out_total_length (out_total_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void push_invalid();
    pending_chars.push_back('{ch: '0, valid: 1'b0, last: 1'b1, total: '0});
  endfunction

  // Expected text for one value under the current buffer size
  function automatic void predict_text(logic [ValueW-1:0] v);
    logic [CharW-1:0]  rev [13];
    logic [ValueW-1:0] n;
    int                len;
    int                digits;
    n = v;
    len = 0;
    digits = 0;
    if (buf_size < 2) begin
      push_invalid();
      return;
    end
    // least significant character first, comma after every third digit
    do begin
      rev[len] = AsciiZero + CharW'(n % 10);
      len++;
      digits++;
      n = n / 10;
      if (n != 0 && digits % 3 == 0) begin
        rev[len] = AsciiComma;
        len++;
      end
    end while (n != 0);
    if (len > buf_size - 1) begin
      push_invalid();
    end else begin
      for (int i = 0; i < len; i++)
        pending_chars.push_back('{ch: rev[len-1-i], valid: 1'b1,
                                  last: (i == len - 1), total: LenW'(len)});
    end
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    logic [63:0] p;
    int          k;
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(999);
      // powers of ten and one below: digit-count boundaries
      2: begin
        p = 1;
        k = $urandom_range(9);
        repeat (k) p = p * 10;
        return ValueW'(p - $urandom_range(1));
      end
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic void report_field(string name, logic [31:0] exp_v,
                                       logic [31:0] act_v);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    errors++;
  endfunction

  // Result checker
  always @(posedge clk) begin : check_char
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual char %0h valid %0b",
                 $time, out_char, out_char_valid);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) report_field("char", want.ch, out_char);
        if (out_char_valid !== want.valid)
          report_field("char_valid", want.valid, out_char_valid);
        if (out_last !== want.last) report_field("last", want.last, out_last);
        if (out_total_length !== want.total)
          report_field("total_length", want.total, out_total_length);
      end
    end
  end

  // Receiver: long hold-off when requested, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one value after an idle gap; returns at the accepting edge
  task automatic offer_value(input logic [ValueW-1:0] v, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every expected character
  task automatic drain_text();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    while (pending_chars.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time,
               pending_chars.size());
      errors++;
      pending_chars.delete();
    end
  endtask

  task automatic write_buffer_size(input logic [BufW-1:0] size);
    drain_text();
    cfg_valid <= 1'b1;
    cfg_buffer_size <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    buf_size = size;
  endtask

  // Stimulus
  initial begin
    dir_row_t rows [18];
    int       send_pcts [4];
    int       stall_pcts [4];
    int       gap;
    int       len;
    logic [ValueW-1:0] v;

    rows = '{
      '{-1, 32'd0,          1'b1, "0"},
      '{-1, 32'd4294967295, 1'b1, "4,294,967,295"},
      '{-1, 32'd999,        1'b1, "999"},
      '{-1, 32'd1000,       1'b1, "1,000"},
      '{-1, 32'd1234567,    1'b0, ""},
      '{-1, 32'd999999,     1'b1, "999,999"},
      '{-1, 32'd1000000,    1'b1, "1,000,000"},
      '{13, 32'd4294967295, 1'b1, ""},
      '{-1, 32'd999999999,  1'b1, "999,999,999"},
      '{0,  32'd5,          1'b1, ""},
      '{1,  32'd0,          1'b1, ""},
      '{2,  32'd7,          1'b1, "7"},
      '{-1, 32'd10,         1'b1, ""},
      '{255, 32'd4294967295, 1'b1, "4,294,967,295"},
      '{-1, 32'd1,          1'b1, "1"},
      '{6,  32'd99999,      1'b1, ""},
      '{-1, 32'd9999,       1'b1, "9,999"},
      '{4,  32'd2147483648, 1'b0, ""}
    };
    send_pcts  = '{0, 78, 0, 29};
    stall_pcts = '{0, 0, 78, 29};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset buffer size first, then the extremes
    foreach (rows[r]) begin
      if (rows[r].buf_sel >= 0) write_buffer_size(BufW'(rows[r].buf_sel));
      offer_value(rows[r].value, 0);
      if (!rows[r].typed) begin
        predict_text(rows[r].value);
      end else if (rows[r].text.len() == 0) begin
        push_invalid();
      end else begin
        len = rows[r].text.len();
        for (int i = 0; i < len; i++)
          pending_chars.push_back('{ch: rows[r].text[i], valid: 1'b1,
                                    last: (i == len - 1), total: LenW'(len)});
      end
    end

    // Random phases with different idling, output stalls and buffer sizes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_buffer_size(8'd255);
        1: write_buffer_size(BufW'($urandom_range(2, 14)));
        2: write_buffer_size(BufW'($urandom_range(0, 16)));
        default: write_buffer_size(BufSizeReset);
      endcase
      stall_pct = stall_pcts[ph];
      for (int k = 0; k < 18; k++) begin
        gap = 0;
        while ($urandom_range(99) < send_pcts[ph]) gap++;
        v = pick_value();
        offer_value(v, gap);
        predict_text(v);
      end
    end

    // Back-pressure: receiver holds off while the sender keeps offering
    write_buffer_size(BufSizeReset);
    stall_pct = 0;
    hold_cycles = 400;
    for (int k = 0; k < 10; k++) begin
      v = $urandom;
      offer_value(v, 0);
      predict_text(v);
    end
    drain_text();

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
